// ===== rtl/xstq_pkg.sv =====
// Shared types and constants for the XOR segment tree range query block.
`default_nettype none

package xstq_pkg;

  localparam logic [1:0] FUNC_ASSIGN = 2'd0;
  localparam logic [1:0] FUNC_XOR    = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LEAF_RD,
    S_LEAF_WR,
    S_LEAF_XWR,
    S_UP,
    S_QUERY,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic leaf_rd;
    logic leaf_wr;
    logic merge_leaf;
    logic up_step;
    logic q_step;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic leaf_ok;
    logic root_next;
    logic q_more;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/xstq_ctrl.sv =====
// Sequencer for clearing, leaf updates, path recompute and range queries.
`default_nettype none

module xstq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [1:0]       in_func,
  input  wire xstq_pkg::status_t sts,
  output xstq_pkg::cmd_t        cmd,
  output logic                  busy,
  output logic                  out_valid
);

  xstq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xstq_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      xstq_pkg::S_CLEAR: begin
        if (sts.clr_last) state_nxt = xstq_pkg::S_IDLE;
      end
      xstq_pkg::S_IDLE: begin
        if (start) begin
          case (in_func)
            xstq_pkg::FUNC_QUERY:  state_nxt = xstq_pkg::S_QUERY;
            xstq_pkg::FUNC_ASSIGN: begin
              if (sts.leaf_ok) state_nxt = xstq_pkg::S_LEAF_WR;
            end
            xstq_pkg::FUNC_XOR: begin
              if (sts.leaf_ok) state_nxt = xstq_pkg::S_LEAF_RD;
            end
            default: state_nxt = xstq_pkg::S_IDLE;
          endcase
        end
      end
      xstq_pkg::S_LEAF_RD:  state_nxt = xstq_pkg::S_LEAF_XWR;
      xstq_pkg::S_LEAF_WR:  state_nxt = xstq_pkg::S_UP;
      xstq_pkg::S_LEAF_XWR: state_nxt = xstq_pkg::S_UP;
      xstq_pkg::S_UP: begin
        if (sts.root_next) state_nxt = xstq_pkg::S_IDLE;
      end
      xstq_pkg::S_QUERY: begin
        // last read data lands in the accumulator in the exit cycle
        if (!sts.q_more) state_nxt = xstq_pkg::S_RESULT;
      end
      xstq_pkg::S_RESULT: state_nxt = xstq_pkg::S_IDLE;
      default: state_nxt = xstq_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      xstq_pkg::S_CLEAR: cmd.clr_step = 1'b1;
      xstq_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      xstq_pkg::S_LEAF_RD: cmd.leaf_rd = 1'b1;
      xstq_pkg::S_LEAF_WR: cmd.leaf_wr = 1'b1;
      xstq_pkg::S_LEAF_XWR: begin
        cmd.leaf_wr    = 1'b1;
        cmd.merge_leaf = 1'b1;
      end
      xstq_pkg::S_UP:     cmd.up_step = 1'b1;
      xstq_pkg::S_QUERY:  cmd.q_step  = sts.q_more;
      xstq_pkg::S_RESULT: out_valid   = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/xstq_dp.sv =====
// Node store, path and range registers, and the query accumulator.
`default_nettype none

module xstq_dp #(
  parameter int LEAF_COUNT  = 1024,
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire xstq_pkg::cmd_t         cmd,
  input  wire logic [9:0]             in_left_index,
  input  wire logic [10:0]            in_right_end,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  output xstq_pkg::status_t           sts,
  output logic [VALUE_WIDTH-1:0]      acc
);

  // heap numbering: root is node 1, node h has children 2h and 2h+1
  localparam int AW         = $clog2(LEAF_COUNT) + 1;
  localparam int IW         = AW + 1;
  localparam int CW         = (IW > 11) ? IW : 11;
  localparam int NODE_DEPTH = 2 * LEAF_COUNT;

  logic [VALUE_WIDTH-1:0] node_mem [0:NODE_DEPTH-1];
  logic [VALUE_WIDTH-1:0] rda_r, rdb_r;
  logic [VALUE_WIDTH-1:0] cur_r, cur_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic [AW-1:0]          h_r, h_nxt;
  logic [AW-1:0]          clr_r;
  logic [IW-1:0]          lo_r, lo_nxt, hi_r, hi_nxt;
  logic                   va_r, vb_r;

  logic [CW-1:0]          l_ext, r_ext, lc, r_clip;
  logic                   empty;
  logic [AW-1:0]          parent, addr_a, addr_b, waddr;
  logic                   we;
  logic [VALUE_WIDTH-1:0] wdata;

  assign l_ext  = CW'(in_left_index);
  assign r_ext  = CW'(in_right_end);
  assign lc     = CW'(LEAF_COUNT);
  assign r_clip = (r_ext > lc) ? lc : r_ext;
  assign empty  = (l_ext >= r_clip);
  assign parent = h_r >> 1;

  assign sts.clr_last  = (clr_r == AW'(NODE_DEPTH - 1));
  assign sts.leaf_ok   = (l_ext < lc);
  assign sts.root_next = (parent == AW'(1));
  assign sts.q_more    = (lo_r < hi_r);

  // read port a: leaf, sibling on the path, or left-side range node
  always_comb begin
    if (cmd.leaf_rd) begin
      addr_a = h_r;
    end else if (cmd.leaf_wr) begin
      addr_a = h_r ^ AW'(1);
    end else if (cmd.up_step) begin
      addr_a = parent ^ AW'(1);
    end else begin
      addr_a = lo_r[AW-1:0];
    end
  end

  assign addr_b = AW'(hi_r - IW'(1));

  always_comb begin
    we    = cmd.clr_step | cmd.leaf_wr | cmd.up_step;
    wdata = cur_r ^ ((cmd.up_step | cmd.merge_leaf) ? rda_r : '0);
    if (cmd.clr_step) begin
      waddr = clr_r;
      wdata = '0;
    end else if (cmd.up_step) begin
      waddr = parent;
    end else begin
      waddr = h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) node_mem[waddr] <= wdata;
    rda_r <= node_mem[addr_a];
    rdb_r <= node_mem[addr_b];
  end

  always_comb begin
    h_nxt   = h_r;
    cur_nxt = cur_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    acc_nxt = acc_r ^ (va_r ? rda_r : '0) ^ (vb_r ? rdb_r : '0);
    if (cmd.load) begin
      h_nxt   = AW'(l_ext + lc);
      cur_nxt = in_value;
      acc_nxt = '0;
      lo_nxt  = empty ? IW'(lc) : IW'(l_ext + lc);
      hi_nxt  = empty ? IW'(lc) : IW'(r_clip + lc);
    end
    if (cmd.leaf_wr | cmd.up_step) cur_nxt = wdata;
    if (cmd.up_step) h_nxt = parent;
    if (cmd.q_step) begin
      lo_nxt = (lo_r + IW'(lo_r[0])) >> 1;
      hi_nxt = (hi_r - IW'(hi_r[0])) >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + AW'(1);
      va_r <= cmd.q_step & lo_r[0];
      vb_r <= cmd.q_step & hi_r[0];
    end
  end

  always_ff @(posedge clk) begin
    h_r   <= h_nxt;
    cur_r <= cur_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// ===== rtl/xor_segment_tree_range_query.sv =====
// Top level: XOR segment tree with point update and range query.
// Sequence: with busy high, assign writes the leaf and then recomputes each node on the path to
// the root; xor-into-leaf reads the leaf first; a query climbs one tree level per step while the
// range still spans nodes, so an empty range goes straight to the result strobe.
// Throughput: one transaction at a time; start is taken only while busy is low.
// Reset: a clearing pass zeroes every node store entry, busy high.
// out_valid is a one-cycle strobe; the receiver cannot stall.
`default_nettype none

module xor_segment_tree_range_query #(
  parameter int LEAF_COUNT  = 1024,
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [9:0]  in_left_index,
  input  wire logic [10:0] in_right_end,
  input  wire logic [63:0] in_value,
  output logic             out_valid,
  output logic [63:0]      out_range_xor
);

  xstq_pkg::cmd_t         cmd;
  xstq_pkg::status_t      sts;
  logic [VALUE_WIDTH-1:0] acc;

  xstq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_func),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  xstq_dp #(
    .LEAF_COUNT  (LEAF_COUNT),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_left_index (in_left_index),
    .in_right_end  (in_right_end),
    .in_value      (in_value[VALUE_WIDTH-1:0]),
    .sts           (sts),
    .acc           (acc)
  );

  assign out_range_xor = 64'(acc);

endmodule

`default_nettype wire

// ===== rtl/xstq_checker.sv =====
// Port-level checks for the XOR segment tree block, bound to the top level.
`default_nettype none

module xstq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  in_func,
  input wire logic        out_valid
);

  logic accept;
  assign accept = start && !busy;

  // results are single-cycle strobes
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held for more than one cycle");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_func == xstq_pkg::FUNC_QUERY |=> busy && !out_valid)
    else $error("query transaction did not start work");

  a_bad_func: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_func != xstq_pkg::FUNC_ASSIGN && in_func != xstq_pkg::FUNC_XOR
      && in_func != xstq_pkg::FUNC_QUERY |=> !busy)
    else $error("unused function code was not dropped");

  // node store clearing runs right after reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> busy)
    else $error("block idle right after reset");

endmodule

bind xor_segment_tree_range_query xstq_checker u_xstq_checker (.*);

`default_nettype wire
